>>> rtl/core/gzhp_pkg.sv
// Shared types and constants for the gzip member header parser.
// No dependencies; imported by gzhp_step and gzip_header_parser.
package gzhp_pkg;

    // Header parse phases.
    typedef enum logic [3:0] {
        PH_FIXED   = 4'd0,
        PH_XLO     = 4'd1,
        PH_XHI     = 4'd2,
        PH_EXTRA   = 4'd3,
        PH_NAME    = 4'd4,
        PH_COMMENT = 4'd5,
        PH_CRCLO   = 4'd6,
        PH_CRCHI   = 4'd7,
        PH_PAYLOAD = 4'd8,
        PH_ERROR   = 4'd9
    } phase_t;

    // Byte classification codes.
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Error causes.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_MAGIC     = 3'd1;
    localparam logic [2:0] ERR_METHOD    = 3'd2;
    localparam logic [2:0] ERR_RESERVED  = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;

    // Fixed header contents.
    localparam logic [7:0] MAGIC0        = 8'h1f;
    localparam logic [7:0] MAGIC1        = 8'h8b;
    localparam logic [7:0] METHOD_DEFL   = 8'h08;
    localparam logic [7:0] RSVD_MASK     = 8'hE0;
    localparam int         FIXED_LEN     = 10;
    localparam logic [3:0] IDX_MAGIC0    = 4'd0;
    localparam logic [3:0] IDX_MAGIC1    = 4'd1;
    localparam logic [3:0] IDX_METHOD    = 4'd2;
    localparam logic [3:0] IDX_FLAGS     = 4'd3;
    localparam logic [3:0] IDX_FIXED_END = 4'(FIXED_LEN - 1);

    // Bit positions in the saved flag nibble (flag byte shifted right by one).
    localparam int FL_HCRC    = 0;
    localparam int FL_EXTRA   = 1;
    localparam int FL_NAME    = 2;
    localparam int FL_COMMENT = 3;

    typedef struct packed {
        phase_t      phase;
        logic [3:0]  fixed_count;
        logic [3:0]  saved_flags;
        logic [15:0] extra_remaining;
        logic [2:0]  sticky_error;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:           PH_FIXED,
        fixed_count:     4'd0,
        saved_flags:     4'd0,
        extra_remaining: 16'd0,
        sticky_error:    ERR_NONE
    };

endpackage

>>> rtl/core/gzhp_step.sv
// Combinational next-state and classification logic for one stream byte.
// Depends on gzhp_pkg.
module gzhp_step (
    input  gzhp_pkg::parse_state_t cur_state,
    input  logic [7:0]             in_byte,
    input  logic                   last_byte,
    output gzhp_pkg::parse_state_t nxt_state,
    output logic [1:0]             byte_kind,
    output logic [2:0]             error_code
);
    import gzhp_pkg::*;

    // First flagged optional section at or after section p, else payload.
    function automatic phase_t section_from(input phase_t p, input logic [3:0] flags);
        phase_t r;
        begin
            if (p <= PH_XLO && flags[FL_EXTRA])
                r = PH_XLO;
            else if (p <= PH_NAME && flags[FL_NAME])
                r = PH_NAME;
            else if (p <= PH_COMMENT && flags[FL_COMMENT])
                r = PH_COMMENT;
            else if (p <= PH_CRCLO && flags[FL_HCRC])
                r = PH_CRCLO;
            else
                r = PH_PAYLOAD;
            return r;
        end
    endfunction

    parse_state_t st;
    logic [1:0]   kind;
    logic [2:0]   code;
    logic [15:0]  xlen;
    logic [15:0]  xdec;
    logic [3:0]   new_flags;

    always_comb
    begin
        st        = cur_state;
        kind      = KIND_HEADER;
        code      = ERR_NONE;
        xlen      = {in_byte, cur_state.extra_remaining[7:0]};
        xdec      = cur_state.extra_remaining - 16'd1;
        new_flags = in_byte[4:1];

        unique case (cur_state.phase)
            PH_FIXED:
            begin
                if (cur_state.fixed_count == IDX_MAGIC0 && in_byte != MAGIC0)
                begin
                    st.phase        = PH_ERROR;
                    st.sticky_error = ERR_MAGIC;
                end
                else if (cur_state.fixed_count == IDX_MAGIC1 && in_byte != MAGIC1)
                begin
                    st.phase        = PH_ERROR;
                    st.sticky_error = ERR_MAGIC;
                end
                else if (cur_state.fixed_count == IDX_METHOD && in_byte != METHOD_DEFL)
                begin
                    st.phase        = PH_ERROR;
                    st.sticky_error = ERR_METHOD;
                end
                else if (cur_state.fixed_count == IDX_FLAGS
                         && (in_byte & RSVD_MASK) != 8'h00)
                begin
                    st.phase        = PH_ERROR;
                    st.sticky_error = ERR_RESERVED;
                end
                else
                begin
                    if (cur_state.fixed_count == IDX_FLAGS)
                        st.saved_flags = new_flags;
                    if (cur_state.fixed_count >= IDX_FIXED_END)
                    begin
                        st.fixed_count = 4'd0;
                        // Flags were captured several bytes earlier.
                        st.phase = section_from(PH_XLO, cur_state.saved_flags);
                    end
                    else
                        st.fixed_count = cur_state.fixed_count + 4'd1;
                end
            end
            PH_XLO:
            begin
                st.extra_remaining = {8'h00, in_byte};
                st.phase           = PH_XHI;
            end
            PH_XHI:
            begin
                st.extra_remaining = xlen;
                st.phase = (xlen != 16'd0) ? PH_EXTRA
                                           : section_from(PH_NAME, cur_state.saved_flags);
            end
            PH_EXTRA:
            begin
                st.extra_remaining = xdec;
                if (xdec == 16'd0)
                    st.phase = section_from(PH_NAME, cur_state.saved_flags);
            end
            PH_NAME:
            begin
                if (in_byte == 8'h00)
                    st.phase = section_from(PH_COMMENT, cur_state.saved_flags);
            end
            PH_COMMENT:
            begin
                if (in_byte == 8'h00)
                    st.phase = section_from(PH_CRCLO, cur_state.saved_flags);
            end
            PH_CRCLO:   st.phase = PH_CRCHI;
            PH_CRCHI:   st.phase = PH_PAYLOAD;
            PH_ERROR:   ;
            default:    kind = KIND_PAYLOAD;
        endcase

        if (kind == KIND_HEADER && st.phase == PH_ERROR)
        begin
            kind = KIND_ERROR;
            code = st.sticky_error;
        end

        // A final byte that leaves the header unfinished is a truncation.
        if (last_byte)
        begin
            if (kind == KIND_HEADER && st.phase != PH_PAYLOAD)
            begin
                kind = KIND_ERROR;
                code = ERR_TRUNCATED;
            end
            st = STATE_RESET;
        end
    end

    assign nxt_state  = st;
    assign byte_kind  = kind;
    assign error_code = code;

endmodule

>>> rtl/core/gzip_header_parser.sv
// gzip member header parser: classifies each stream byte as header, payload or error.
// The result is registered: it is valid in the cycle after the input transaction.
// One byte per cycle unless out_ready stalls; parse state updates in the accepting cycle.
// The result register is the only buffer; input is taken whenever it is empty or drained.
// Reset (rst_n low, asynchronous) returns the parser to the start of the fixed header
// and empties the result register. Depends on gzhp_pkg and gzhp_step.
module gzip_header_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] byte_kind,
    output logic [2:0] error_code,
    output logic       end_marker
);
    import gzhp_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    logic         out_valid_reg;
    logic [7:0]   out_byte_reg;
    logic [1:0]   byte_kind_reg;
    logic [1:0]   byte_kind_next;
    logic [2:0]   error_code_reg;
    logic [2:0]   error_code_next;
    logic         end_marker_reg;
    logic         in_fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    gzhp_step u_step (
        .cur_state  (state_reg),
        .in_byte    (in_byte),
        .last_byte  (last_byte),
        .nxt_state  (state_next),
        .byte_kind  (byte_kind_next),
        .error_code (error_code_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                state_reg <= state_next;
            if (in_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_byte_reg   <= in_byte;
            byte_kind_reg  <= byte_kind_next;
            error_code_reg <= error_code_next;
            end_marker_reg <= last_byte;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_kind  = byte_kind_reg;
    assign error_code = error_code_reg;
    assign end_marker = end_marker_reg;

    // An error cause is reported only on error bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_kind != KIND_ERROR |-> error_code == ERR_NONE)
        else $error("error code set on a non-error byte");

    // The error phase always carries its cause.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_ERROR |-> state_reg.sticky_error != ERR_NONE)
        else $error("error phase without a cause");

    // A final byte restarts the parser.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last_byte |=> state_reg == STATE_RESET)
        else $error("parser not restarted after final byte");

    // The fixed header counter never runs past the fixed header.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.fixed_count <= IDX_FIXED_END)
        else $error("fixed header counter out of range");

    // Payload bytes are only reported once the header has been passed.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && byte_kind_next == KIND_PAYLOAD |-> state_reg.phase != PH_FIXED)
        else $error("payload byte inside fixed header");

endmodule

>>> tb/tb_gzip_header_parser.sv
// Self-checking testbench for gzip_header_parser: directed header cases, then random streams.
// A behavioral predictor classifies every accepted byte; results are matched in order.
// Depends on gzhp_pkg and the gzip_header_parser RTL.
`timescale 1ns / 1ps

module tb_gzip_header_parser;
    import gzhp_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [2:0] code;
        logic       fin;
    } verdict_t;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       typed;
        logic [1:0] kind;
        logic [2:0] code;
    } dir_row_t;

    localparam int N_DIRECTED = 26;
    localparam int PHASE_ITEMS = 500;

    // Rows with typed set carry their expected kind and code; the rest go to the predictor.
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{8'h00, 1'b1, 1'b1, KIND_ERROR, ERR_MAGIC},
        '{MAGIC0, 1'b0, 1'b0, KIND_HEADER, ERR_NONE},
        '{MAGIC1, 1'b0, 1'b0, KIND_HEADER, ERR_NONE},
        '{8'h07, 1'b1, 1'b1, KIND_ERROR, ERR_METHOD},
        '{MAGIC0, 1'b0, 1'b0, KIND_HEADER, ERR_NONE},
        '{MAGIC1, 1'b0, 1'b0, KIND_HEADER, ERR_NONE},
        '{METHOD_DEFL, 1'b0, 1'b0, KIND_HEADER, ERR_NONE},
        '{8'hE0, 1'b0, 1'b1, KIND_ERROR, ERR_RESERVED},
        '{8'hFF, 1'b1, 1'b1, KIND_ERROR, ERR_RESERVED},
        '{MAGIC0, 1'b0, 1'b0, KIND_HEADER, ERR_NONE},
        '{MAGIC1, 1'b0, 1'b0, KIND_HEADER, ERR_NONE},
        '{METHOD_DEFL, 1'b0, 1'b0, KIND_HEADER, ERR_NONE},
        '{8'h1F, 1'b0, 1'b0, KIND_HEADER, ERR_NONE},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, KIND_HEADER, ERR_NONE},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, KIND_HEADER, ERR_NONE},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, KIND_HEADER, ERR_NONE},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, ERR_NONE},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, ERR_NONE},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, ERR_NONE},
        '{8'h00, 1'b0, 1'b0, KIND_HEADER, ERR_NONE},
        '{8'hA5, 1'b0, 1'b0, KIND_HEADER, ERR_NONE},
        '{8'h5A, 1'b1, 1'b0, KIND_HEADER, ERR_NONE},
        '{MAGIC0, 1'b1, 1'b1, KIND_ERROR, ERR_TRUNCATED}
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       last_byte;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic [1:0] byte_kind;
    logic [2:0] error_code;
    logic       end_marker;

    // Predicted parser state.
    phase_t      parse_phase = PH_FIXED;
    logic [3:0]  hdr_count = '0;
    logic [3:0]  flag_bits = '0;
    logic [15:0] extra_left = '0;
    logic [2:0]  err_latched = ERR_NONE;

    verdict_t verdict_q[$];
    int       send_idle_pct;
    int       recv_stall_pct;
    int       bytes_sent;
    int       streams_sent;
    int       mismatches;
    int       header_seen;
    int       payload_seen;
    int       error_seen;

    gzip_header_parser uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_kind  (byte_kind),
        .error_code (error_code),
        .end_marker (end_marker)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic void restart_parse();
        parse_phase = PH_FIXED;
        hdr_count   = '0;
        flag_bits   = '0;
        extra_left  = '0;
        err_latched = ERR_NONE;
    endfunction

    function automatic void latch_error(input logic [2:0] cause);
        err_latched = cause;
        parse_phase = PH_ERROR;
    endfunction

    // First optional section at or after the given one that the flag byte enables.
    function automatic phase_t next_section(input phase_t from);
        if (from <= PH_XLO && flag_bits[FL_EXTRA])
            return PH_XLO;
        if (from <= PH_NAME && flag_bits[FL_NAME])
            return PH_NAME;
        if (from <= PH_COMMENT && flag_bits[FL_COMMENT])
            return PH_COMMENT;
        if (from <= PH_CRCLO && flag_bits[FL_HCRC])
            return PH_CRCLO;
        return PH_PAYLOAD;
    endfunction

    function automatic verdict_t classify_byte(input logic [7:0] b, input logic fin);
        verdict_t v;
        v.data = b;
        v.kind = KIND_HEADER;
        v.code = ERR_NONE;
        v.fin  = fin;
        case (parse_phase)
            PH_FIXED:
            begin
                if (hdr_count == IDX_MAGIC0 && b != MAGIC0)
                    latch_error(ERR_MAGIC);
                else if (hdr_count == IDX_MAGIC1 && b != MAGIC1)
                    latch_error(ERR_MAGIC);
                else if (hdr_count == IDX_METHOD && b != METHOD_DEFL)
                    latch_error(ERR_METHOD);
                else if (hdr_count == IDX_FLAGS && (b & RSVD_MASK) != 8'h00)
                    latch_error(ERR_RESERVED);
                else
                begin
                    if (hdr_count == IDX_FLAGS)
                        flag_bits = b[4:1];
                    if (hdr_count >= IDX_FIXED_END)
                    begin
                        hdr_count   = '0;
                        parse_phase = next_section(PH_XLO);
                    end
                    else
                        hdr_count = hdr_count + 4'd1;
                end
            end
            PH_XLO:
            begin
                extra_left  = {8'h00, b};
                parse_phase = PH_XHI;
            end
            PH_XHI:
            begin
                extra_left  = {b, extra_left[7:0]};
                parse_phase = (extra_left != 16'd0) ? PH_EXTRA : next_section(PH_NAME);
            end
            PH_EXTRA:
            begin
                extra_left = extra_left - 16'd1;
                if (extra_left == 16'd0)
                    parse_phase = next_section(PH_NAME);
            end
            PH_NAME:
                if (b == 8'h00)
                    parse_phase = next_section(PH_COMMENT);
            PH_COMMENT:
                if (b == 8'h00)
                    parse_phase = next_section(PH_CRCLO);
            PH_CRCLO:
                parse_phase = PH_CRCHI;
            PH_CRCHI:
                parse_phase = PH_PAYLOAD;
            PH_ERROR:
                ;
            default:
                v.kind = KIND_PAYLOAD;
        endcase
        if (v.kind == KIND_HEADER && parse_phase == PH_ERROR)
        begin
            v.kind = KIND_ERROR;
            v.code = err_latched;
        end
        if (fin)
        begin
            // A final byte that leaves the header unfinished is a truncation.
            if (v.kind == KIND_HEADER && parse_phase != PH_PAYLOAD)
            begin
                v.kind = KIND_ERROR;
                v.code = ERR_TRUNCATED;
            end
            restart_parse();
        end
        return v;
    endfunction

    // Called just after a rising edge; returns just after the edge of acceptance or the gap.
    task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                             input logic [1:0] kind, input logic [2:0] code);
        verdict_t v;
        int       gap;
        in_valid  <= 1'b1;
        in_byte   <= b;
        last_byte <= fin;
        do
            @(posedge clk);
        while (!in_ready);
        v = classify_byte(b, fin);
        if (typed)
        begin
            v.kind = kind;
            v.code = code;
        end
        verdict_q.push_back(v);
        bytes_sent++;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Well-formed member with random content, or a corrupted, truncated or noise stream.
    task automatic send_stream();
        logic [7:0] bytes_q[$];
        logic [7:0] flags;
        int         mode;
        int         hi;
        int         lo;
        int         pos;
        int         hdr_len;
        mode = $urandom_range(99);
        if (mode < 5)
            repeat ($urandom_range(1, 8)) bytes_q.push_back(8'($urandom));
        else
        begin
            flags = 8'($urandom_range(0, 31));
            bytes_q.push_back(MAGIC0);
            bytes_q.push_back(MAGIC1);
            bytes_q.push_back(METHOD_DEFL);
            bytes_q.push_back(flags);
            repeat (6) bytes_q.push_back(8'($urandom));
            if (flags[FL_EXTRA + 1])
            begin
                hi = ($urandom_range(19) == 0) ? 1 : 0;
                lo = hi ? $urandom_range(0, 40) : $urandom_range(0, 8);
                bytes_q.push_back(8'(lo));
                bytes_q.push_back(8'(hi));
                repeat (hi * 256 + lo) bytes_q.push_back(8'($urandom));
            end
            if (flags[FL_NAME + 1])
            begin
                repeat ($urandom_range(0, 5)) bytes_q.push_back(8'($urandom_range(1, 255)));
                bytes_q.push_back(8'h00);
            end
            if (flags[FL_COMMENT + 1])
            begin
                repeat ($urandom_range(0, 5)) bytes_q.push_back(8'($urandom_range(1, 255)));
                bytes_q.push_back(8'h00);
            end
            if (flags[FL_HCRC + 1])
                repeat (2) bytes_q.push_back(8'($urandom));
            hdr_len = bytes_q.size();
            if (mode < 15)
            begin
                pos = $urandom_range(0, 3);
                if (pos == 3)
                    bytes_q[3] = bytes_q[3] | (8'h20 << $urandom_range(0, 2));
                else
                    bytes_q[pos] = 8'($urandom);
            end
            if (mode >= 15 && mode < 30)
                while (bytes_q.size() > $urandom_range(1, hdr_len))
                    void'(bytes_q.pop_back());
            else
                repeat ($urandom_range(0, 12)) bytes_q.push_back(8'($urandom));
        end
        foreach (bytes_q[i])
            send_byte(bytes_q[i], i == bytes_q.size() - 1, 1'b0, KIND_HEADER, ERR_NONE);
        streams_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (verdict_q.size() > 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: byte %h kind %0d code %0d end %0d",
                             out_byte, byte_kind, error_code, end_marker);
            end
            else
            begin
                want = verdict_q.pop_front();
                if (out_byte !== want.data || byte_kind !== want.kind ||
                    error_code !== want.code || end_marker !== want.fin)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want %h %0d %0d %0d, got %h %0d %0d %0d",
                                 want.data, want.kind, want.code, want.fin,
                                 out_byte, byte_kind, error_code, end_marker);
                end
            end
            case (byte_kind)
                KIND_HEADER:  header_seen++;
                KIND_PAYLOAD: payload_seen++;
                default:      error_seen++;
            endcase
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_byte        = 8'h00;
        last_byte      = 1'b0;
        send_idle_pct  = 37;
        recv_stall_pct = 86;
        bytes_sent     = 0;
        streams_sent   = 0;
        mismatches     = 0;
        header_seen    = 0;
        payload_seen   = 0;
        error_seen     = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_byte(DIRECTED[i].data, DIRECTED[i].fin, DIRECTED[i].typed,
                      DIRECTED[i].kind, DIRECTED[i].code);

        while (bytes_sent < PHASE_ITEMS)
            send_stream();
        // Let the pipeline run dry before the idle pattern flips.
        drain_results();
        send_idle_pct  = 86;
        recv_stall_pct = 37;
        while (bytes_sent < 2 * PHASE_ITEMS)
            send_stream();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (bytes_sent < 3 * PHASE_ITEMS)
            send_stream();

        drain_results();
        repeat (4) @(posedge clk);

        $display("covered %0d streams, %0d bytes: %0d header, %0d payload, %0d error",
                 streams_sent, bytes_sent, header_seen, payload_seen, error_seen);
        $display("mismatching results: %0d", mismatches);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
